[rtl/core/ipv4np_pkg.sv]
// Shared types and constants for the IPv4 network prefix parser.
// No dependencies; used by ipv4np_step and the top level.
`default_nettype none

package ipv4np_pkg;

   localparam logic [7:0]  OCTET_MAX = 8'hff;
   localparam logic [4:0]  TOP_SHIFT = 5'd24;
   localparam logic [8:0]  ADDR_BITS = 9'd32;
   localparam logic [8:0]  NUM_CAP   = 9'd256;

   // Character codes the parser recognizes
   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [7:0]  CHAR_DOT   = 8'h2e;
   localparam logic [7:0]  CHAR_SLASH = 8'h2f;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_UX    = 8'h58;
   localparam logic [7:0]  CHAR_LX    = 8'h78;

   // Parser state carried from one character to the next
   typedef struct packed {
      logic [31:0] address_accum;
      logic [8:0]  number_accum;
      logic [1:0]  octet_index;
      logic        in_prefix_part;
      logic        error_seen;
   } parse_state_type;

   // Result of one string
   typedef struct packed {
      logic [31:0] network_address;
      logic        parse_error;
   } parse_result_type;

endpackage : ipv4np_pkg

`default_nettype wire

[rtl/core/ipv4np_step.sv]
// Next-state and result logic for one character of the prefix parser.
// Depends on ipv4np_pkg.
`default_nettype none

module ipv4np_step (
   input  wire logic [7:0]                  char_code,
   input  wire ipv4np_pkg::parse_state_type cur_state,
   output ipv4np_pkg::parse_state_type      next_state,
   output ipv4np_pkg::parse_result_type     result
);

   logic        is_digit;
   logic [3:0]  digit_val;
   logic [12:0] num_grown;
   logic [8:0]  num_sat;
   logic        merge_ok;
   logic [4:0]  octet_shift;
   logic [31:0] merged_addr;
   logic [31:0] prefix_mask;
   logic        prefix_bad;

   // Decimal accumulate with saturation at 256
   assign is_digit  = (char_code >= ipv4np_pkg::CHAR_ZERO) &&
                      (char_code <= ipv4np_pkg::CHAR_NINE);
   assign digit_val = 4'(char_code - ipv4np_pkg::CHAR_ZERO);
   assign num_grown = ({4'b0, cur_state.number_accum} * 13'd10) + {9'b0, digit_val};
   assign num_sat   = (num_grown > {4'b0, ipv4np_pkg::NUM_CAP}) ?
                      ipv4np_pkg::NUM_CAP : num_grown[8:0];

   // Octet merge into the address, top byte first
   assign merge_ok    = (cur_state.number_accum <= {1'b0, ipv4np_pkg::OCTET_MAX});
   assign octet_shift = ipv4np_pkg::TOP_SHIFT - {cur_state.octet_index, 3'b000};
   assign merged_addr = cur_state.address_accum |
                        ({24'b0, cur_state.number_accum[7:0]} << octet_shift);

   // Network mask from the prefix length
   assign prefix_bad  = (cur_state.number_accum == 9'd0) ||
                        (cur_state.number_accum > ipv4np_pkg::ADDR_BITS);
   assign prefix_mask = (cur_state.number_accum == ipv4np_pkg::ADDR_BITS) ? 32'hffff_ffff :
                        ~(32'hffff_ffff >> cur_state.number_accum);

   // Result on end of string
   always_comb begin
      result.parse_error     = 1'b1;
      result.network_address = 32'hffff_ffff;
      if (!cur_state.error_seen) begin
         if (cur_state.in_prefix_part) begin
            if (!prefix_bad) begin
               result.parse_error     = 1'b0;
               result.network_address = cur_state.address_accum & prefix_mask;
            end
         end else if (merge_ok) begin
            result.parse_error     = 1'b0;
            result.network_address = merged_addr;
         end
      end
   end

   // State update per character
   always_comb begin
      next_state = cur_state;
      if (char_code == ipv4np_pkg::CHAR_NUL) begin
         next_state = '0;
      end else if (!cur_state.error_seen) begin
         if (is_digit) begin
            next_state.number_accum = num_sat;
         end else if (cur_state.in_prefix_part) begin
            next_state.error_seen = 1'b1;
         end else if (char_code == ipv4np_pkg::CHAR_DOT) begin
            if (!merge_ok || (cur_state.octet_index == 2'd3)) begin
               next_state.error_seen = 1'b1;
            end else begin
               next_state.address_accum = merged_addr;
               next_state.number_accum  = 9'd0;
               next_state.octet_index   = cur_state.octet_index + 2'd1;
            end
         end else if (char_code == ipv4np_pkg::CHAR_SLASH) begin
            if (!merge_ok) begin
               next_state.error_seen = 1'b1;
            end else begin
               next_state.address_accum  = merged_addr;
               next_state.number_accum   = 9'd0;
               next_state.in_prefix_part = 1'b1;
            end
         end else if ((char_code == ipv4np_pkg::CHAR_LX) ||
                      (char_code == ipv4np_pkg::CHAR_UX)) begin
            if (cur_state.number_accum != 9'd0) begin
               next_state.error_seen = 1'b1;
            end
         end else begin
            next_state.error_seen = 1'b1;
         end
      end
   end

endmodule : ipv4np_step

`default_nettype wire

[rtl/core/ipv4_network_prefix_parser_top.sv]
// IPv4 network prefix parser: one character register, parser state, result register.
// Depends on ipv4np_pkg and ipv4np_step.
//
// Takes a dotted IPv4 network string (for example "127.1/8" or "10.x.x.x") one
// character per request and gives one response when the NUL terminator arrives:
// the address with the first octet in bits 31:24 and host bits below any /prefix
// cleared, or all ones with rsp_parse_error set. One character is taken every
// clock unless a NUL waits behind a held response; each passes an input register
// and the accumulate-and-compare logic, and a NUL's result is registered as the
// response. A held response stalls only a following NUL, not ordinary characters.
`default_nettype none

module ipv4_network_prefix_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_network_address,
   output logic             rsp_parse_error
);

   logic                          char_valid_ff, char_valid_in;
   logic [7:0]                    char_code_ff, char_code_in;
   ipv4np_pkg::parse_state_type   state_ff, state_in;
   ipv4np_pkg::parse_state_type   step_state;
   ipv4np_pkg::parse_result_type  step_result;
   logic                          rsp_valid_ff, rsp_valid_in;
   ipv4np_pkg::parse_result_type  rsp_data_ff, rsp_data_in;
   logic                          rsp_free;
   logic                          char_is_nul;
   logic                          char_go;
   logic                          req_take;

   ipv4np_step u_step (
      .char_code  (char_code_ff),
      .cur_state  (state_ff),
      .next_state (step_state),
      .result     (step_result)
   );

   // Handshake control
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign char_is_nul = (char_code_ff == ipv4np_pkg::CHAR_NUL);
   assign char_go     = char_valid_ff && (!char_is_nul || rsp_free);
   assign req_ready   = !reset && (!char_valid_ff || char_go);
   assign req_take    = req_valid && req_ready;

   // Next values
   always_comb begin
      char_valid_in = char_valid_ff;
      char_code_in  = char_code_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (char_go) begin
         char_valid_in = 1'b0;
         state_in      = step_state;
      end
      if (req_take) begin
         char_valid_in = 1'b1;
         char_code_in  = req_char_code;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (char_go && char_is_nul) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         char_valid_ff <= 1'b0;
         state_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         char_valid_ff <= char_valid_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_code_ff <= char_code_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_network_address = rsp_data_ff.network_address;
   assign rsp_parse_error     = rsp_data_ff.parse_error;

endmodule : ipv4_network_prefix_parser_top

`default_nettype wire

[rtl/core/ipv4np_checker.sv]
// Port-level checks for the IPv4 network prefix parser, bound to the top level.
// Depends on ipv4np_pkg and ipv4_network_prefix_parser_top.
`default_nettype none

module ipv4np_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_char_code,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_network_address,
   input wire logic        rsp_parse_error
);

   // A held response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // An error response always carries all ones
   a_err_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_error |-> rsp_network_address == 32'hffff_ffff)
      else $error("error response without all-ones address");

   // A new response follows an accepted terminator request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_char_code == ipv4np_pkg::CHAR_NUL), 2))
      else $error("response without terminator request");

   // Reset empties the response register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule : ipv4np_checker

bind ipv4_network_prefix_parser_top ipv4np_checker u_ipv4np_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_char_code       (req_char_code),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_network_address (rsp_network_address),
   .rsp_parse_error     (rsp_parse_error)
);

`default_nettype wire

[tb/ipv4_network_prefix_parser_top_tb.sv]
// Self-checking testbench for ipv4_network_prefix_parser_top: drives character requests,
// predicts each NUL-terminated string's response and compares it field by field.
// Depends on ipv4np_pkg and the parser RTL.
`default_nettype none

module ipv4_network_prefix_parser_top_tb;

   localparam int unsigned CHARS_WANTED = 1800;
   localparam int unsigned MAX_GAP      = 12;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef logic [7:0] char_queue_type[$];

   // Expected-response store plus a cycle-free model of the parser state
   class prefix_scoreboard;
      ipv4np_pkg::parse_state_type  parser;
      ipv4np_pkg::parse_result_type expected_results[$];
      int unsigned      mismatches;
      int unsigned      strings_seen;
      int unsigned      chars_seen;
      int unsigned      results_checked;
      int unsigned      malformed_results;

      function new();
         parser            = '0;
         mismatches        = 0;
         strings_seen      = 0;
         chars_seen        = 0;
         results_checked   = 0;
         malformed_results = 0;
      endfunction

      task report(input string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      // Advance the parser model by one accepted character request
      function void note_request(input logic [7:0] c);
         ipv4np_pkg::parse_result_type res;
         logic [31:0]      mask;
         int unsigned      n;
         chars_seen++;
         if (c == ipv4np_pkg::CHAR_NUL) begin
            res.network_address = '1;
            res.parse_error     = parser.error_seen;
            if (!parser.error_seen) begin
               if (parser.in_prefix_part) begin
                  if (parser.number_accum == 0 ||
                      parser.number_accum > ipv4np_pkg::ADDR_BITS) begin
                     res.parse_error = 1'b1;
                  end else begin
                     mask = (parser.number_accum == ipv4np_pkg::ADDR_BITS) ? '1 :
                            ~(32'hffff_ffff >> parser.number_accum);
                     res.network_address = parser.address_accum & mask;
                  end
               end else if (parser.number_accum > ipv4np_pkg::OCTET_MAX) begin
                  res.parse_error = 1'b1;
               end else begin
                  res.network_address = parser.address_accum |
                     (32'(parser.number_accum) <<
                      (ipv4np_pkg::TOP_SHIFT - 8 * parser.octet_index));
               end
            end
            expected_results.push_back(res);
            strings_seen++;
            parser = '0;
            return;
         end
         // everything up to the terminator is ignored once malformed
         if (parser.error_seen) return;
         if (c >= ipv4np_pkg::CHAR_ZERO && c <= ipv4np_pkg::CHAR_NINE) begin
            n = parser.number_accum * 10 + (c - ipv4np_pkg::CHAR_ZERO);
            parser.number_accum = (n > ipv4np_pkg::NUM_CAP) ? ipv4np_pkg::NUM_CAP : n[8:0];
         end else if (parser.in_prefix_part) begin
            parser.error_seen = 1'b1;
         end else if (c == ipv4np_pkg::CHAR_DOT) begin
            // a fourth dot or an octet above 255 spoils the string
            if (parser.number_accum > ipv4np_pkg::OCTET_MAX || parser.octet_index == 2'd3) begin
               parser.error_seen = 1'b1;
            end else begin
               parser.address_accum |=
                  32'(parser.number_accum) << (ipv4np_pkg::TOP_SHIFT - 8 * parser.octet_index);
               parser.number_accum = '0;
               parser.octet_index++;
            end
         end else if (c == ipv4np_pkg::CHAR_SLASH) begin
            if (parser.number_accum > ipv4np_pkg::OCTET_MAX) begin
               parser.error_seen = 1'b1;
            end else begin
               parser.address_accum |=
                  32'(parser.number_accum) << (ipv4np_pkg::TOP_SHIFT - 8 * parser.octet_index);
               parser.number_accum   = '0;
               parser.in_prefix_part = 1'b1;
            end
         end else if (c == ipv4np_pkg::CHAR_LX || c == ipv4np_pkg::CHAR_UX) begin
            // wildcard octet; "0x" still counts as zero
            if (parser.number_accum != 0) parser.error_seen = 1'b1;
         end else begin
            parser.error_seen = 1'b1;
         end
      endfunction

      // Compare one accepted response with the oldest expectation
      task check_response(input logic [31:0] address, input logic error_flag);
         ipv4np_pkg::parse_result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected response addr=%h err=%b", address, error_flag));
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         if (want.parse_error) malformed_results++;
         if (address !== want.network_address)
            report($sformatf("network_address got %h want %h", address, want.network_address));
         if (error_flag !== want.parse_error)
            report($sformatf("parse_error got %b want %b", error_flag, want.parse_error));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_network_address;
   logic        rsp_parse_error;

   prefix_scoreboard sb = new();
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned idle_cycles = 0;

   ipv4_network_prefix_parser_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_code       (req_char_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_network_address (rsp_network_address),
      .rsp_parse_error     (rsp_parse_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Present one character and hold it until the parser takes it
   task send_char(input logic [7:0] c);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (!req_ready);
      sb.note_request(c);
   endtask

   task send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_char(text[i]);
      send_char(ipv4np_pkg::CHAR_NUL);
   endtask

   function automatic void push_digits(ref char_queue_type s, input int unsigned value,
                                       input int unsigned zeros);
      string digits;
      digits = $sformatf("%0d", value);
      repeat (zeros) s.push_back(ipv4np_pkg::CHAR_ZERO);
      for (int i = 0; i < digits.len(); i++) s.push_back(digits[i]);
   endfunction

   // Mostly well-formed dotted strings; about one in five gets damaged
   function automatic char_queue_type random_string();
      char_queue_type s;
      int unsigned octets;
      int unsigned pick;
      int unsigned spot;
      octets = $urandom_range(1, 4);
      for (int i = 0; i < octets; i++) begin
         if (i != 0) s.push_back(ipv4np_pkg::CHAR_DOT);
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            s.push_back(pick[0] ? ipv4np_pkg::CHAR_LX : ipv4np_pkg::CHAR_UX);
         end else if (pick == 3) begin
            s.push_back(ipv4np_pkg::CHAR_ZERO);
            s.push_back(ipv4np_pkg::CHAR_LX);
         end else if (pick == 4) begin
            push_digits(s, $urandom_range(256, 999), 0);
         end else if (pick == 5) begin
            push_digits(s, 255, 0);
         end else if (pick == 6) begin
            push_digits(s, $urandom_range(0, 255), $urandom_range(1, 3));
         end else begin
            push_digits(s, $urandom_range(0, 255), 0);
         end
      end
      if ($urandom_range(0, 1) == 1) begin
         s.push_back(ipv4np_pkg::CHAR_SLASH);
         pick = $urandom_range(0, 19);
         if (pick == 1) push_digits(s, 0, 0);
         else if (pick == 2) push_digits(s, $urandom_range(33, 999), 0);
         else if (pick == 3) push_digits(s, 32, 0);
         else if (pick > 3) push_digits(s, $urandom_range(1, 32), 0);
      end
      if ($urandom_range(0, 4) == 0) begin
         spot = $urandom_range(0, s.size());
         pick = $urandom_range(0, 3);
         case (pick)
            0: begin
               s.insert(spot, 8'($urandom_range(0, 255)));
            end
            1: begin
               s.insert(spot, ipv4np_pkg::CHAR_DOT);
            end
            2: begin
               s.insert(spot, ipv4np_pkg::CHAR_LX);
               s.insert(spot, 8'($urandom_range(ipv4np_pkg::CHAR_ZERO + 1,
                                                ipv4np_pkg::CHAR_NINE)));
            end
            default: begin
               repeat ($urandom_range(2, 6)) s.insert(spot, 8'($urandom_range(0, 255)));
            end
         endcase
      end
      s.push_back(ipv4np_pkg::CHAR_NUL);
      return s;
   endfunction

   // Request side: directed strings, then random ones
   initial begin
      char_queue_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty string, full prefix, wildcards with shortest prefix, overflow,
      // prefix out of range, empty prefix, wildcard after digits
      send_text("");
      send_text("255/32");
      send_text("0x.X/1");
      send_text("999");
      send_text("/33");
      send_text("/");
      send_text("5x");

      while (sb.chars_seen < CHARS_WANTED) begin
         req_quiet = ($urandom_range(0, 4) == 0);
         s = random_string();
         foreach (s[i]) send_char(s[i]);
      end
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d strings in %0d characters", sb.strings_seen, sb.chars_seen);
      $display("checked %0d responses, %0d of them malformed",
               sb.results_checked, sb.malformed_results);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Response side: random back-pressure, with quiet stretches
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_quiet = ~rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_network_address, rsp_parse_error);
      end
   end

   // Watchdog: give up after a long run of cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
